[hdl/tts_pkg.sv]
// shared types, constants and fixed-point helpers of the tridiagonal solver
package tts_pkg;

    localparam int MAX_ROWS  = 32;
    localparam int FRAC_BITS = 16;
    localparam int IDX_W     = 6;
    localparam int ADDR_W    = $clog2(MAX_ROWS);
    localparam int CNT_W     = $clog2(MAX_ROWS + 1);

    localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] Q_MIN = 32'sh80000000;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_PIVOT = 2'd1;
    localparam logic [1:0] ST_OVER  = 2'd2;

    localparam int DIV_W = 32 + FRAC_BITS + 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_G,
        S_DEN,
        S_MUL_B,
        S_DIV_G,
        S_DIV_B,
        S_STORE,
        S_EMIT0,
        S_EMITN,
        S_RD,
        S_MULX,
        S_EMITX,
        S_EMITL
    } state_t;

    typedef enum logic [1:0] {
        MSRC_PREV_G,
        MSRC_PREV_B,
        MSRC_BACK
    } msrc_t;

    typedef enum logic [2:0] {
        OSEL_ZERO,
        OSEL_BETA,
        OSEL_X
    } osel_t;

    // controller to datapath
    typedef struct packed {
        logic        load_row;
        logic        mul_go;
        msrc_t       mul_src;
        logic        den_go;
        logic        div_g_go;
        logic        div_b_go;
        logic        store;
        logic        rd_go;
        logic        x_go;
        logic        x_from_beta;
        logic        out_go;
        osel_t       out_sel;
        logic [IDX_W-1:0] out_idx;
        logic [1:0]  out_status;
        logic        out_last;
        logic        clear;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic div_busy;
        logic den_zero;
        logic out_full;
    } stat_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'(signed'(Q_MAX)))
            return Q_MAX;
        else if (v < 66'(signed'(Q_MIN)))
            return Q_MIN;
        else
            return v[31:0];
    endfunction

endpackage

[hdl/tts_stream_if.sv]
// valid/ready channel carrying one word of type word_t
interface tts_stream_if #(parameter type word_t = logic) ();
    logic  valid;
    logic  ready;
    word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[hdl/tts_divider.sv]
// restoring divider: saturated signed fixed-point quotient, one bit a cycle
module tts_divider (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] num,
    input  logic signed [31:0] den,
    output logic               busy,
    output logic signed [31:0] quot
);
    import tts_pkg::*;

    localparam int CW = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] dvd_reg, dvd_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [31:0]      dvs_reg, dvs_next;
    logic             neg_reg, neg_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [DIV_W:0]   trial;
    logic [DIV_W-1:0] shifted;
    logic signed [DIV_W+1:0] signed_q;

    always_comb
    begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        shifted   = {rem_reg[DIV_W-2:0], dvd_reg[DIV_W-1]};
        trial     = {1'b0, shifted} - {{(DIV_W-31){1'b0}}, dvs_reg};
        if (start)
        begin
            // |num| << FRAC_BITS fits in DIV_W bits
            dvd_next  = DIV_W'(num[31] ? (33'd0 - 33'(num)) : 33'(num)) << FRAC_BITS;
            dvs_next  = den[31] ? (32'd0 - den) : den;
            neg_next  = num[31] ^ den[31];
            rem_next  = '0;
            cnt_next  = CW'(DIV_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[DIV_W])
                rem_next = trial[DIV_W-1:0];
            else
                rem_next = shifted;
            dvd_next = {dvd_reg[DIV_W-2:0], ~trial[DIV_W]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign signed_q = neg_reg ? -$signed({2'b00, dvd_reg}) : $signed({2'b00, dvd_reg});
    assign quot     = sat32(66'(signed_q));
    assign busy     = busy_reg;
endmodule

[hdl/tts_datapath.sv]
// datapath: coefficient registers, multiplier, divider, row stores, output register
module tts_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  tts_pkg::cmd_t       cmd,
    output tts_pkg::stat_t      stat,
    input  logic signed [31:0]  sub_coef,
    input  logic signed [31:0]  diag_coef,
    input  logic signed [31:0]  super_coef,
    input  logic signed [31:0]  rhs_value,
    input  logic [tts_pkg::ADDR_W-1:0] wr_addr,
    input  logic [tts_pkg::ADDR_W-1:0] rd_addr,
    input  logic                out_ready,
    output logic                out_valid,
    output logic signed [31:0]  out_solution,
    output logic [tts_pkg::IDX_W-1:0] out_row_index,
    output logic [1:0]          out_status,
    output logic                out_last
);
    import tts_pkg::*;

    logic signed [31:0] gamma_store [MAX_ROWS];
    logic signed [31:0] beta_store [MAX_ROWS];

    logic signed [31:0] a_reg, b_reg, c_reg, d_reg;
    logic signed [31:0] pg_reg, pg_next, pb_reg, pb_next;
    logic signed [31:0] prod_reg, den_reg, bnum_reg, g_reg, be_reg, x_reg;
    logic signed [31:0] gr_reg, br_reg;
    logic signed [31:0] mul_a, mul_b, div_num;
    logic signed [63:0] prod_full;
    logic signed [31:0] prod_q;
    logic               div_start, div_busy;
    logic signed [31:0] div_quot;
    logic               ov_reg, ov_next;
    logic signed [31:0] os_reg, os_next;
    logic [IDX_W-1:0]   oi_reg;
    logic [1:0]         ost_reg;
    logic               ol_reg;

    // multiplier operands
    always_comb
    begin
        unique case (cmd.mul_src)
            MSRC_PREV_G: begin mul_a = a_reg;  mul_b = pg_reg; end
            MSRC_PREV_B: begin mul_a = a_reg;  mul_b = pb_reg; end
            default:     begin mul_a = gr_reg; mul_b = x_reg;  end
        endcase
    end

    // arithmetic shift floors toward minus infinity
    assign prod_full = mul_a * mul_b;
    assign prod_q    = sat32(66'(prod_full >>> FRAC_BITS));

    assign div_start = cmd.div_g_go | cmd.div_b_go;
    assign div_num   = cmd.div_g_go ? sat32(-66'(c_reg)) : bnum_reg;

    tts_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (den_reg),
        .busy  (div_busy),
        .quot  (div_quot)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load_row)
        begin
            a_reg <= sub_coef;
            b_reg <= diag_coef;
            c_reg <= super_coef;
            d_reg <= rhs_value;
        end
        if (cmd.mul_go)
            prod_reg <= prod_q;
        if (cmd.den_go)
            den_reg <= sat32(66'(prod_reg) + 66'(b_reg));
        // prod holds a*prev_beta here
        if (cmd.div_g_go)
            bnum_reg <= sat32(66'(d_reg) - 66'(prod_q));
        if (cmd.div_b_go)
            g_reg <= (den_reg == 32'sd0) ? 32'sd0 : div_quot;
        if (cmd.store)
        begin
            be_reg <= (den_reg == 32'sd0) ? 32'sd0 : div_quot;
            gamma_store[wr_addr] <= g_reg;
            beta_store[wr_addr]  <= (den_reg == 32'sd0) ? 32'sd0 : div_quot;
        end
        if (cmd.rd_go)
        begin
            gr_reg <= gamma_store[rd_addr];
            br_reg <= beta_store[rd_addr];
        end
        if (cmd.x_go)
            x_reg <= cmd.x_from_beta ? be_reg : sat32(66'(prod_reg) + 66'(br_reg));
        if (cmd.out_go)
        begin
            oi_reg  <= cmd.out_idx;
            ost_reg <= cmd.out_status;
            ol_reg  <= cmd.out_last;
        end
        os_reg <= os_next;
    end

    always_comb
    begin
        os_next = os_reg;
        pg_next = pg_reg;
        pb_next = pb_reg;
        ov_next = ov_reg;
        if (cmd.out_go)
        begin
            unique case (cmd.out_sel)
                OSEL_ZERO: os_next = 32'sd0;
                OSEL_BETA: os_next = be_reg;
                default:   os_next = x_reg;
            endcase
            ov_next = 1'b1;
        end
        else if (out_ready)
            ov_next = 1'b0;
        if (cmd.store)
        begin
            pg_next = g_reg;
            pb_next = (den_reg == 32'sd0) ? 32'sd0 : div_quot;
        end
        if (cmd.clear)
        begin
            pg_next = 32'sd0;
            pb_next = 32'sd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pg_reg <= 32'sd0;
            pb_reg <= 32'sd0;
            ov_reg <= 1'b0;
        end
        else
        begin
            pg_reg <= pg_next;
            pb_reg <= pb_next;
            ov_reg <= ov_next;
        end
    end

    assign stat.div_busy = div_busy;
    assign stat.den_zero = (den_reg == 32'sd0);
    assign stat.out_full = ov_reg;

    assign out_valid     = ov_reg;
    assign out_solution  = os_reg;
    assign out_row_index = oi_reg;
    assign out_status    = ost_reg;
    assign out_last      = ol_reg;
endmodule

[hdl/tts_controller.sv]
// controller: sequences elimination, division and back substitution
module tts_controller (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_last,
    output logic                in_ready,
    output tts_pkg::cmd_t       cmd,
    input  tts_pkg::stat_t      stat,
    output logic [tts_pkg::ADDR_W-1:0] wr_addr,
    output logic [tts_pkg::ADDR_W-1:0] rd_addr
);
    import tts_pkg::*;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic             last_reg, last_next;
    logic [1:0]       err_reg, err_next;
    logic             accept;
    logic [1:0]       st;

    assign in_ready = (state_reg == S_IDLE) && !stat.out_full;
    assign accept   = in_valid && in_ready;
    assign st       = err_reg[0] ? ST_PIVOT : ST_OK;
    assign wr_addr  = cnt_reg[ADDR_W-1:0];
    assign rd_addr  = ADDR_W'(i_reg - IDX_W'(1));

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        i_next     = i_reg;
        last_next  = last_reg;
        err_next   = err_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    last_next = in_last;
                    if (!in_last && cnt_reg == CNT_W'(MAX_ROWS))
                        err_next[1] = 1'b1;
                    else if (in_last && (err_reg[1] || cnt_reg == CNT_W'(MAX_ROWS)))
                    begin
                        err_next[1] = 1'b1;
                        state_next  = S_EMITL;
                    end
                    else
                        state_next = S_MUL_G;
                end
            end
            S_MUL_G: state_next = S_DEN;
            S_DEN:   state_next = S_MUL_B;
            // the last row runs the gamma division too, its quotient is unused
            S_MUL_B: state_next = S_DIV_G;
            S_DIV_G:
            begin
                if (stat.den_zero)
                    err_next[0] = 1'b1;
                state_next = S_DIV_B;
            end
            S_DIV_B:
                if (!stat.div_busy)
                    state_next = S_STORE;
            S_STORE:
            begin
                if (stat.den_zero)
                    err_next[0] = 1'b1;
                if (!stat.div_busy)
                begin
                    if (last_reg)
                    begin
                        i_next     = IDX_W'(cnt_reg) + IDX_W'(1);
                        state_next = S_EMIT0;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_EMIT0:
                if (!stat.out_full)
                    state_next = S_EMITN;
            S_EMITN:
                if (!stat.out_full)
                begin
                    i_next     = i_reg - 1'b1;
                    state_next = (i_reg == IDX_W'(1)) ? S_EMITL : S_RD;
                end
            S_RD:    state_next = S_MULX;
            S_MULX:  state_next = S_EMITX;
            // new x lands in x_reg, emitted by the next pass through S_EMITN
            S_EMITX: state_next = S_EMITN;
            S_EMITL:
                if (!stat.out_full)
                begin
                    state_next = S_IDLE;
                    cnt_next   = '0;
                    err_next   = '0;
                    i_next     = '0;
                end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.mul_src = MSRC_BACK;
        cmd.out_sel = OSEL_ZERO;
        cmd.out_status = st;
        unique case (state_reg)
            S_IDLE:  cmd.load_row = accept;
            S_MUL_G:
            begin
                cmd.mul_go  = 1'b1;
                cmd.mul_src = MSRC_PREV_G;
            end
            S_DEN:   cmd.den_go = 1'b1;
            S_MUL_B:
            begin
                cmd.mul_go  = 1'b1;
                cmd.mul_src = MSRC_PREV_B;
            end
            S_DIV_G:
            begin
                cmd.mul_src  = MSRC_PREV_B;
                cmd.div_g_go = 1'b1;
            end
            S_DIV_B: cmd.div_b_go = !stat.div_busy;
            S_STORE: cmd.store = !stat.div_busy;
            S_EMIT0:
            begin
                cmd.out_go  = !stat.out_full;
                cmd.out_idx = '0;
                cmd.x_go        = 1'b1;
                cmd.x_from_beta = 1'b1;
            end
            S_EMITN:
            begin
                cmd.out_go  = !stat.out_full;
                cmd.out_sel = OSEL_X;
                cmd.out_idx = i_reg;
            end
            S_RD:    cmd.rd_go = 1'b1;
            S_MULX:  cmd.mul_go = 1'b1;
            S_EMITX: cmd.x_go = 1'b1;
            S_EMITL:
            begin
                cmd.out_go     = !stat.out_full;
                cmd.out_idx    = err_reg[1] ? '0 : IDX_W'(cnt_reg) + IDX_W'(2);
                cmd.out_status = err_reg[1] ? ST_OVER : st;
                cmd.out_last   = 1'b1;
                cmd.clear      = !stat.out_full;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            i_reg     <= '0;
            last_reg  <= 1'b0;
            err_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            i_reg     <= i_next;
            last_reg  <= last_next;
            err_reg   <= err_next;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_ROWS))
        else $error("row count past capacity");
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_IDLE || state_reg == S_MUL_G || state_reg == S_EMITL))
        else $error("bad state after accepted word");
    a_emitl_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMITL && !stat.out_full) |=> (cnt_reg == '0 && err_reg == '0))
        else $error("run state not cleared");
endmodule

[hdl/tridiagonal_thomas_solver.sv]
// top level of the tridiagonal solver
// Takes one row word at a time (sub, diag, super, rhs in signed Q16.16, plus
// last_row). Each row keeps the block busy after it is accepted, while the
// 49-step restoring divider runs twice per row (gamma then beta, the gamma
// quotient of the last row being unused). The last row is then followed by n+2
// words, each back-substitution word going through the single 32x32
// multiplier, order: boundary 0, x[n]..x[1], boundary n+1 (a single word with
// overflow status if the rows overflowed). A new row is taken only once the
// previous one is finished and the output register is empty. Overflow or a zero
// pivot is reported in status.
module tridiagonal_thomas_solver (
    input  logic clk,
    input  logic rst_n,
    tts_stream_if.sink   in_ch,
    tts_stream_if.source out_ch
);
    import tts_pkg::*;

    cmd_t  cmd;
    stat_t stat;
    logic [ADDR_W-1:0] wr_addr, rd_addr;

    tts_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_last  (in_ch.data.last_row),
        .in_ready (in_ch.ready),
        .cmd      (cmd),
        .stat     (stat),
        .wr_addr  (wr_addr),
        .rd_addr  (rd_addr)
    );

    tts_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .sub_coef      (in_ch.data.sub_coef),
        .diag_coef     (in_ch.data.diag_coef),
        .super_coef    (in_ch.data.super_coef),
        .rhs_value     (in_ch.data.rhs_value),
        .wr_addr       (wr_addr),
        .rd_addr       (rd_addr),
        .out_ready     (out_ch.ready),
        .out_valid     (out_ch.valid),
        .out_solution  (out_ch.data.solution),
        .out_row_index (out_ch.data.row_index),
        .out_status    (out_ch.data.status),
        .out_last      (out_ch.data.last_out)
    );
endmodule

[test/tb_tridiagonal_thomas_solver.sv]
// testbench of the tridiagonal solver: row stimulus, solution prediction and checking
module tb_tridiagonal_thomas_solver;
    timeunit 1ns;
    timeprecision 1ps;

    import tts_pkg::*;

    typedef struct packed {
        logic signed [31:0] sub_coef;
        logic signed [31:0] diag_coef;
        logic signed [31:0] super_coef;
        logic signed [31:0] rhs_value;
        logic               last_row;
    } row_word_t;

    typedef struct packed {
        logic signed [31:0] solution;
        logic [IDX_W-1:0]   row_index;
        logic [1:0]         status;
        logic               last_out;
    } sol_word_t;

    localparam longint ONE_Q = 64'sd1 << FRAC_BITS;

    logic clk;
    logic rst_n;

    tts_stream_if #(.word_t(row_word_t)) in_ch ();
    tts_stream_if #(.word_t(sol_word_t)) out_ch ();

    tridiagonal_thomas_solver u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // solver state as predicted
    logic signed [31:0] gamma_mem [MAX_ROWS];
    logic signed [31:0] beta_mem [MAX_ROWS];
    logic signed [31:0] last_gamma;
    logic signed [31:0] last_beta;
    int unsigned        rows_taken;
    logic [1:0]         run_flags;

    sol_word_t solutions_due [$];
    int        fail_count;
    logic      row_taken;
    int        burst_left;
    logic      hold_req;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic longint clamp32(input longint v);
        if (v > longint'(Q_MAX))
            return longint'(Q_MAX);
        else if (v < longint'(Q_MIN))
            return longint'(Q_MIN);
        return v;
    endfunction

    // floor of the scaled product
    function automatic longint fx_mul(input longint x, input longint y);
        return clamp32((x * y) >>> FRAC_BITS);
    endfunction

    // quotient truncated toward zero
    function automatic longint fx_div(input longint num, input longint den);
        return clamp32((num * ONE_Q) / den);
    endfunction

    function automatic void push_solution(input longint val, input int idx,
                                          input logic [1:0] st, input logic lst);
        sol_word_t w;
        w.solution  = val[31:0];
        w.row_index = idx[IDX_W-1:0];
        w.status    = st;
        w.last_out  = lst;
        solutions_due = {solutions_due, w};
    endfunction

    function automatic void clear_run_state();
        last_gamma = '0;
        last_beta  = '0;
        rows_taken = 0;
        run_flags  = 2'b00;
    endfunction

    function automatic void eliminate_row(input row_word_t r);
        longint a, b, c, d, den, g, be, x;
        int unsigned n;
        logic [1:0] st;
        a  = r.sub_coef;
        b  = r.diag_coef;
        c  = r.super_coef;
        d  = r.rhs_value;
        g  = 0;
        be = 0;
        if (!r.last_row)
        begin
            if (rows_taken >= MAX_ROWS)
            begin
                run_flags[1] = 1'b1;
                return;
            end
            den = clamp32(fx_mul(a, last_gamma) + b);
            if (den == 0)
                run_flags[0] = 1'b1;
            else
            begin
                g  = fx_div(clamp32(-c), den);
                be = fx_div(clamp32(d - fx_mul(a, last_beta)), den);
            end
            gamma_mem[rows_taken] = g[31:0];
            beta_mem[rows_taken]  = be[31:0];
            last_gamma = g[31:0];
            last_beta  = be[31:0];
            rows_taken++;
            return;
        end
        if (rows_taken + 1 > MAX_ROWS)
            run_flags[1] = 1'b1;
        if (run_flags[1])
        begin
            push_solution(0, 0, ST_OVER, 1'b1);
            clear_run_state();
            return;
        end
        den = clamp32(fx_mul(a, last_gamma) + b);
        if (den == 0)
            run_flags[0] = 1'b1;
        else
            be = fx_div(clamp32(d - fx_mul(a, last_beta)), den);
        st = run_flags[0] ? ST_PIVOT : ST_OK;
        n  = rows_taken + 1;
        push_solution(0, 0, st, 1'b0);
        x = be;
        push_solution(x, n, st, 1'b0);
        for (int i = n - 1; i >= 1; i--)
        begin
            x = clamp32(fx_mul(gamma_mem[i-1], x) + beta_mem[i-1]);
            push_solution(x, i, st, 1'b0);
        end
        push_solution(0, n + 1, st, 1'b1);
        clear_run_state();
    endfunction

    // everything sampled here sees pre-edge values
    always @(posedge clk)
    begin
        sol_word_t want;
        sol_word_t got;
        row_taken <= in_ch.valid && in_ch.ready;
        if (rst_n && in_ch.valid && in_ch.ready)
            eliminate_row(in_ch.data);
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = out_ch.data;
            if (solutions_due.size() == 0)
            begin
                fail_count++;
                $display("%0t: unexpected word, actual %h", $time, got);
            end
            else
            begin
                want = solutions_due.pop_front();
                if (got.solution !== want.solution)
                begin
                    fail_count++;
                    $display("%0t: solution expected %h actual %h", $time,
                             want.solution, got.solution);
                end
                if (got.row_index !== want.row_index)
                begin
                    fail_count++;
                    $display("%0t: row_index expected %0d actual %0d", $time,
                             want.row_index, got.row_index);
                end
                if (got.status !== want.status)
                begin
                    fail_count++;
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, got.status);
                end
                if (got.last_out !== want.last_out)
                begin
                    fail_count++;
                    $display("%0t: last_out expected %b actual %b", $time,
                             want.last_out, got.last_out);
                end
            end
        end
    end

    // receiver: long hold on request, otherwise stretches of free flow and random stalls
    initial
    begin
        int stretch;
        bit stalling;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stretch  = $urandom_range(5, 60);
            stalling = $urandom_range(0, 1);
            repeat (stretch)
            begin
                @(negedge clk);
                if (hold_req)
                begin
                    out_ch.ready = 1'b0;
                    repeat (400) @(negedge clk);
                    hold_req = 1'b0;
                end
                out_ch.ready = stalling ? ($urandom_range(0, 99) < 60) : 1'b1;
            end
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_row(input row_word_t r);
        if (burst_left == 0)
        begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 12) : 0) @(negedge clk);
            burst_left = $urandom_range(1, 8);
        end
        in_ch.valid = 1'b1;
        in_ch.data  = r;
        do @(negedge clk); while (!row_taken);
        burst_left--;
    endtask

    function automatic row_word_t make_row(input longint a, input longint b, input longint c,
                                           input longint d, input logic lst);
        row_word_t r;
        r.sub_coef   = a[31:0];
        r.diag_coef  = b[31:0];
        r.super_coef = c[31:0];
        r.rhs_value  = d[31:0];
        r.last_row   = lst;
        return r;
    endfunction

    // diagonally dominant row with random content, now and then fully random fields or a zeroed sub and diag
    function automatic row_word_t random_row(input logic lst);
        row_word_t r;
        if ($urandom_range(0, 99) < 15)
        begin
            r = {$urandom, $urandom, $urandom, $urandom, lst};
            return r;
        end
        r.sub_coef   = $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
        r.super_coef = $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
        r.diag_coef  = $signed($urandom_range(32'h40000, 32'h200000));
        if ($urandom_range(0, 1))
            r.diag_coef = -r.diag_coef;
        r.rhs_value  = $urandom;
        if ($urandom_range(0, 1))
            r.rhs_value = r.rhs_value >>> $urandom_range(4, 12);
        if ($urandom_range(0, 49) == 0)
        begin
            r.sub_coef  = '0;
            r.diag_coef = '0;
        end
        r.last_row = lst;
        return r;
    endfunction

    task automatic send_system(input int n);
        for (int i = 1; i <= n; i++)
            send_row(random_row(i == n));
    endtask

    task automatic drain();
        in_ch.valid = 1'b0;
        wait (solutions_due.size() == 0);
        repeat (200) @(negedge clk);
    endtask

    task automatic test_single_rows();
        send_row(make_row(0, ONE_Q, 0, Q_MAX, 1'b1));
        send_row(make_row(0, ONE_Q, 0, Q_MIN, 1'b1));
        send_row(make_row(Q_MAX, -ONE_Q, Q_MIN, Q_MIN, 1'b1));
        send_row(make_row(Q_MIN, 1, Q_MAX, Q_MAX, 1'b1));
        send_row(make_row(-1, Q_MIN, -1, -1, 1'b1));
        send_row(make_row(0, 0, 0, ONE_Q, 1'b1));
        drain();
    endtask

    task automatic test_small_systems();
        send_row(make_row(0, 2 * ONE_Q, -ONE_Q, ONE_Q, 1'b0));
        send_row(make_row(-ONE_Q, 2 * ONE_Q, -ONE_Q, 0, 1'b0));
        send_row(make_row(-ONE_Q, 2 * ONE_Q, 0, ONE_Q, 1'b1));
        send_row(make_row(Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b0));
        send_row(make_row(Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b1));
        drain();
    endtask

    task automatic test_zero_pivot();
        // pivot vanishes on an inner row, then on the closing row
        send_row(make_row(0, 0, ONE_Q, ONE_Q, 1'b0));
        send_row(make_row(ONE_Q, ONE_Q, 0, ONE_Q, 1'b1));
        send_row(make_row(0, ONE_Q, ONE_Q, ONE_Q, 1'b0));
        send_row(make_row(ONE_Q, ONE_Q, 0, ONE_Q, 1'b1));
        drain();
    endtask

    task automatic test_capacity();
        send_system(MAX_ROWS);
        drain();
        // one row too many at the closing row, then dropped rows
        send_system(MAX_ROWS + 1);
        send_system(MAX_ROWS + 3);
        send_system(2);
        drain();
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        for (int k = 0; k < 6; k++)
            send_system($urandom_range(1, 3));
        drain();
    endtask

    task automatic test_random();
        int sent;
        int n;
        sent = 0;
        while (sent < 140)
        begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, MAX_ROWS) : $urandom_range(1, 6);
            send_system(n);
            sent += n;
        end
        drain();
    endtask

    initial
    begin
        #2_000_000;
        $display("tb_tridiagonal_thomas_solver: FAIL");
        $finish;
    end

    initial
    begin
        rst_n       = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        fail_count  = 0;
        burst_left  = 0;
        hold_req    = 1'b0;
        row_taken   = 1'b0;
        clear_run_state();
        foreach (gamma_mem[i])
        begin
            gamma_mem[i] = '0;
            beta_mem[i]  = '0;
        end
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_single_rows();
        test_small_systems();
        test_zero_pivot();
        test_capacity();
        test_backpressure();
        test_random();
        if (fail_count == 0)
            $display("tb_tridiagonal_thomas_solver: PASS");
        else
            $display("tb_tridiagonal_thomas_solver: FAIL");
        $finish;
    end

endmodule
